// ===== hdl/pth_pkg.sv =====
package pth_pkg;

  localparam int WORD_W     = 32;
  localparam int CFG_N      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 64;
  localparam int LANES      = 3;
  // Exact column sum: three 64-bit products plus the shifted translation term
  localparam int SUM_W      = 66;
  localparam int MAG_W      = 65;
  // Quotient bits resolved in each divider stage
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = WORD_W / DIV_STEP;
  // Front stages (input, multiply, sum, round, magnitude, range check) + divider + output
  localparam int LATENCY    = 6 + DIV_STAGES + 1;

  localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // Per-word sideband that travels with the divider pipeline
  typedef struct packed {
    logic                          valid;
    logic                          last;
    logic                          divd;
    logic                          wov;
    logic                          wzero;
    logic [LANES-1:0]              sneg;
    logic [LANES-1:0]              neg;
    logic [LANES-1:0]              presat;
    logic [LANES-1:0]              rov;
    logic [LANES-1:0][WORD_W-1:0]  rnd;
  } side_t;

endpackage

// ===== hdl/point_transform_homogeneous_top.sv =====
// Transforms one point per clock by the 4x4 matrix in the eight row registers, with a
// perspective divide by w whenever the rounded w is not 1.0. A word is taken on every
// cycle where start is high; busy is never raised. Each word comes back on the out_*
// ports with done high for one cycle, in the order the words were taken.
// The pipeline is the divider, 16 stages of two quotient bits each, behind six
// front stages (input, multiply, column sum, round, magnitude, range check) and one
// output register. The receiver cannot stall, so results must be taken as they come.
// Write the matrix only while no word is in flight.
module point_transform_homogeneous_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [pth_pkg::WORD_W-1:0] in_x,
  input  logic signed [pth_pkg::WORD_W-1:0] in_y,
  input  logic signed [pth_pkg::WORD_W-1:0] in_z,
  input  logic                           in_last,
  input  logic                           cfg_we,
  input  logic [pth_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pth_pkg::CFG_W-1:0]      cfg_data,
  output logic                           done,
  output logic signed [pth_pkg::WORD_W-1:0] out_x,
  output logic signed [pth_pkg::WORD_W-1:0] out_y,
  output logic signed [pth_pkg::WORD_W-1:0] out_z,
  output logic                           divided,
  output logic                           overflow,
  output logic                           out_last
);
  import pth_pkg::*;

  localparam logic [WORD_W-1:0] ONE  = WORD_W'(1) << FRAC_BITS;
  localparam logic [SUM_W:0]    HALF = (SUM_W+1)'(1) << (FRAC_BITS-1);

  // Round to nearest (ties up) and saturate; returns {overflow, value}
  function automatic logic [WORD_W:0] rnd_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W:0] t;
    logic signed [SUM_W:0] sh;
    logic                  fits;
    t    = $signed({s[SUM_W-1], s}) + $signed(HALF);
    sh   = t >>> FRAC_BITS;
    fits = (&sh[SUM_W:WORD_W-1]) || !(|sh[SUM_W:WORD_W-1]);
    if (fits) rnd_sat = {1'b0, sh[WORD_W-1:0]};
    else      rnd_sat = {1'b1, (sh[SUM_W] ? SAT_MIN : SAT_MAX)};
  endfunction

  // Matrix registers
  logic [CFG_W-1:0] cfg [CFG_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[0] <= 64'h0000_0000_0001_0000;
      cfg[1] <= 64'h0;
      cfg[2] <= 64'h0001_0000_0000_0000;
      cfg[3] <= 64'h0;
      cfg[4] <= 64'h0;
      cfg[5] <= 64'h0000_0000_0001_0000;
      cfg[6] <= 64'h0;
      cfg[7] <= 64'h0001_0000_0000_0000;
    end else if (cfg_we) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // Stage 1: capture word
  logic                     v1, last1;
  logic signed [WORD_W-1:0] pt1 [LANES];

  always_ff @(posedge clk) begin
    v1     <= rst ? 1'b0 : start;
    last1  <= in_last;
    pt1[0] <= in_x;
    pt1[1] <= in_y;
    pt1[2] <= in_z;
  end

  // Stage 2: twelve products
  logic                       v2, last2;
  logic signed [2*WORD_W-1:0] p2 [LANES][4];

  always_ff @(posedge clk) begin
    v2    <= rst ? 1'b0 : v1;
    last2 <= last1;
    for (int r = 0; r < LANES; r++) begin
      for (int c = 0; c < 4; c++) begin
        p2[r][c] <= pt1[r]
                  * $signed(cfg[CFG_IDX_W'(r*2 + (c>>1))][(c&1)*WORD_W +: WORD_W]);
      end
    end
  end

  // Stage 3: column sums with translation row
  logic                    v3, last3;
  logic signed [SUM_W-1:0] sum3 [4];

  always_ff @(posedge clk) begin
    v3    <= rst ? 1'b0 : v2;
    last3 <= last2;
    for (int c = 0; c < 4; c++) begin
      sum3[c] <= SUM_W'(p2[0][c]) + SUM_W'(p2[1][c]) + SUM_W'(p2[2][c])
               + (SUM_W'($signed(cfg[CFG_IDX_W'(6 + (c>>1))][(c&1)*WORD_W +: WORD_W]))
                  <<< FRAC_BITS);
    end
  end

  // Stage 4: round w and the plain results
  logic                    v4, last4, div4, wov4;
  logic [WORD_W-1:0]       wq4;
  logic signed [SUM_W-1:0] sum4 [LANES];
  logic [WORD_W-1:0]       rnd4 [LANES];
  logic [LANES-1:0]        rov4;
  logic [WORD_W:0]         wr;
  logic [WORD_W:0]         lr [LANES];

  always_comb begin
    wr = rnd_sat(sum3[3]);
    for (int i = 0; i < LANES; i++) lr[i] = rnd_sat(sum3[i]);
  end

  always_ff @(posedge clk) begin
    v4    <= rst ? 1'b0 : v3;
    last4 <= last3;
    wq4   <= wr[WORD_W-1:0];
    wov4  <= wr[WORD_W];
    div4  <= wr[WORD_W-1:0] != ONE;
    for (int i = 0; i < LANES; i++) begin
      sum4[i] <= sum3[i];
      rnd4[i] <= lr[i][WORD_W-1:0];
      rov4[i] <= lr[i][WORD_W];
    end
  end

  // Stage 5: magnitudes and signs for the divider
  side_t             sd5;
  logic [MAG_W-1:0]  mag5 [LANES];
  logic [WORD_W-1:0] wm5;

  always_ff @(posedge clk) begin
    sd5.valid  <= rst ? 1'b0 : v4;
    sd5.last   <= last4;
    sd5.divd   <= div4;
    sd5.wov    <= wov4;
    sd5.wzero  <= wq4 == '0;
    sd5.presat <= '0;
    wm5        <= wq4[WORD_W-1] ? WORD_W'(-wq4) : wq4;
    for (int i = 0; i < LANES; i++) begin
      sd5.sneg[i] <= sum4[i][SUM_W-1];
      sd5.neg[i]  <= sum4[i][SUM_W-1] ^ wq4[WORD_W-1];
      sd5.rov[i]  <= rov4[i];
      sd5.rnd[i]  <= rnd4[i];
      mag5[i]     <= sum4[i][SUM_W-1] ? MAG_W'(-sum4[i]) : MAG_W'(sum4[i]);
    end
  end

  // Stage 6: flag quotients of 2^32 or more, load remainder and dividend
  side_t                       ds  [DIV_STAGES+1];
  logic [WORD_W-1:0]           dwm [DIV_STAGES+1];
  logic [LANES-1:0][2*WORD_W-1:0] dwk [DIV_STAGES+1];
  side_t                       sd6_next;

  always_comb begin
    sd6_next = sd5;
    for (int i = 0; i < LANES; i++) begin
      sd6_next.presat[i] = mag5[i][MAG_W-1:WORD_W] >= {1'b0, wm5};
    end
    if (rst) sd6_next.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    ds[0]  <= sd6_next;
    dwm[0] <= wm5;
    for (int i = 0; i < LANES; i++) begin
      dwk[0][i] <= mag5[i][2*WORD_W-1:0];
    end
  end

  // Divider: restoring, DIV_STEP quotient bits per stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [LANES-1:0][2*WORD_W-1:0] wk_next;
    side_t                          sd_next;

    always_comb begin : step
      logic [WORD_W:0]   t;
      logic [WORD_W-1:0] rem;
      logic [WORD_W-1:0] q;
      logic              ge;
      sd_next = ds[k];
      if (rst) sd_next.valid = 1'b0;
      wk_next = dwk[k];
      for (int i = 0; i < LANES; i++) begin
        rem = dwk[k][i][2*WORD_W-1:WORD_W];
        q   = dwk[k][i][WORD_W-1:0];
        for (int j = 0; j < DIV_STEP; j++) begin
          t   = {rem, q[WORD_W-1]};
          ge  = t >= {1'b0, dwm[k]};
          rem = ge ? WORD_W'(t - {1'b0, dwm[k]}) : t[WORD_W-1:0];
          q   = {q[WORD_W-2:0], ge};
        end
        wk_next[i] = {rem, q};
      end
    end

    always_ff @(posedge clk) begin
      ds[k+1]  <= sd_next;
      dwm[k+1] <= dwm[k];
      dwk[k+1] <= wk_next;
    end
  end

  // Output stage: pick plain, zero-w or divided result and saturate
  side_t             sf;
  logic [WORD_W-1:0] res  [LANES];
  logic [LANES-1:0]  lov;
  logic [WORD_W-1:0] quo;

  assign sf = ds[DIV_STAGES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      quo = dwk[DIV_STAGES][i][WORD_W-1:0];
      if (!sf.divd) begin
        res[i] = sf.rnd[i];
        lov[i] = sf.rov[i];
      end else if (sf.wzero) begin
        res[i] = sf.sneg[i] ? SAT_MIN : SAT_MAX;
        lov[i] = 1'b1;
      end else if (sf.presat[i]) begin
        res[i] = sf.neg[i] ? SAT_MIN : SAT_MAX;
        lov[i] = 1'b1;
      end else if (sf.neg[i]) begin
        lov[i] = quo > SAT_MIN;
        res[i] = lov[i] ? SAT_MIN : WORD_W'(-quo);
      end else begin
        lov[i] = quo[WORD_W-1];
        res[i] = lov[i] ? SAT_MAX : quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    done     <= rst ? 1'b0 : sf.valid;
    out_x    <= res[0];
    out_y    <= res[1];
    out_z    <= res[2];
    divided  <= sf.divd;
    overflow <= sf.wov | (|lov);
    out_last <= sf.last;
  end

endmodule

// ===== hdl/pth_checker.sv =====
module pth_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic in_last,
  input logic out_last
);
  import pth_pkg::*;

  // Every word taken comes back after the fixed latency
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted word did not complete");

  // No result without a word taken the fixed latency earlier
  a_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching word");

  // Last mark follows its word
  a_last: assert property (@(posedge clk) disable iff (rst)
    done |-> out_last == $past(in_last, LATENCY))
    else $error("last mark out of place");

  // Reset flushes the pipeline
  a_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");

endmodule

bind point_transform_homogeneous_top pth_checker u_pth_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .in_last  (in_last),
  .out_last (out_last)
);
